### src/sot_pkg.sv
// ----------------------------------------------------------------------------
// sot_pkg: shared constants for the shape overlap test
// Default coordinate width and fixed size-field width.
// ----------------------------------------------------------------------------
package sot_pkg;

    // Default width of signed x / y coordinates
    localparam int SOT_COORD_BITS = 12;

    // Width of the unsigned width / height / radius fields
    localparam int SOT_SIZE_BITS  = 10;

endpackage

### src/shape_overlap_test_core.sv
// ----------------------------------------------------------------------------
// shape_overlap_test_core: box / circle overlap test
// Checks two shapes, each an axis-aligned box or a circle, for overlap.
// ----------------------------------------------------------------------------
// Usage
//   Input beat: a shape pair is taken at a rising edge with start high and
//   busy low. busy is always low, so a new pair can be offered every cycle.
//   Each shape is a box (left x, top y, width w, height h, closed spans) or
//   a circle (centre x, y, radius in w, h ignored). An unused shape forces
//   hit low.
//   Result beat: done is high for exactly one cycle and marks hit. There is
//   no back-pressure; the consumer must take the beat when done is high.
// Timing
//   Three register stages: input capture, squared distances, result.
//   Throughput is one pair per cycle; the squaring stage (four coordinate
//   squares and one threshold square, in parallel) sets the cycle budget.
// Reset
//   rst_n clears all beat-valid flags; no result beat is produced until a
//   pair has been taken after reset. The payload registers are not reset.
// ----------------------------------------------------------------------------
module shape_overlap_test_core #(
    parameter int COORD_BITS = sot_pkg::SOT_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               start,
    output logic                               busy,
    input  logic                               a_unused,
    input  logic                               a_circle,
    input  logic signed [COORD_BITS-1:0]       a_x,
    input  logic signed [COORD_BITS-1:0]       a_y,
    input  logic [sot_pkg::SOT_SIZE_BITS-1:0]  a_w,
    input  logic [sot_pkg::SOT_SIZE_BITS-1:0]  a_h,
    input  logic                               b_unused,
    input  logic                               b_circle,
    input  logic signed [COORD_BITS-1:0]       b_x,
    input  logic signed [COORD_BITS-1:0]       b_y,
    input  logic [sot_pkg::SOT_SIZE_BITS-1:0]  b_w,
    input  logic [sot_pkg::SOT_SIZE_BITS-1:0]  b_h,

    output logic                               done,
    output logic                               hit
);

    // Edge coordinates (x + w) need one bit over the wider of coord and size.
    localparam int SZW = sot_pkg::SOT_SIZE_BITS;
    localparam int XW  = ((COORD_BITS > SZW + 1) ? COORD_BITS : SZW + 1) + 1;
    // Differences between edge values
    localparam int DW  = XW + 1;
    // Square of a difference (always non-negative)
    localparam int SQW = 2 * DW - 1;
    // Sum of two squares
    localparam int SW  = SQW + 1;
    // Threshold: radius, or sum of radii plus one
    localparam int LW  = SZW + 1;

    // How the final stage forms hit
    typedef enum logic [1:0] {
        MODE_FLAG,    // result already known, carried in flag
        MODE_CC,      // circle vs circle: dist^2 < (ra + rb + 1)^2
        MODE_CORNER   // circle outside box on both axes: any corner <= r^2
    } mode_t;

    // ------------------------------------------------------------------
    // Stage 0: input capture
    // ------------------------------------------------------------------
    logic                          in_vld_reg;
    logic                          in_a_unused_reg, in_b_unused_reg;
    logic                          in_a_circle_reg, in_b_circle_reg;
    logic signed [COORD_BITS-1:0]  in_a_x_reg, in_a_y_reg, in_b_x_reg, in_b_y_reg;
    logic [SZW-1:0]                in_a_w_reg, in_a_h_reg, in_b_w_reg, in_b_h_reg;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_a_unused_reg <= a_unused;
            in_a_circle_reg <= a_circle;
            in_a_x_reg      <= a_x;
            in_a_y_reg      <= a_y;
            in_a_w_reg      <= a_w;
            in_a_h_reg      <= a_h;
            in_b_unused_reg <= b_unused;
            in_b_circle_reg <= b_circle;
            in_b_x_reg      <= b_x;
            in_b_y_reg      <= b_y;
            in_b_w_reg      <= b_w;
            in_b_h_reg      <= b_h;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: classify, edge tests, differences and squares
    // ------------------------------------------------------------------
    logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [DW-1:0] cx, cy, cw;              // circle shape
    logic signed [DW-1:0] lx, ty, rx, byt;         // other shape edges
    logic signed [DW-1:0] ow, oh;
    logic signed [DW-1:0] dxl, dxr, dyt, dyb;
    logic signed [2*DW-1:0] pxl, pxr, pyt, pyb;
    logic [LW-1:0]        lim;
    logic [2*LW-1:0]      lim_sq;
    logic                 both_circ, both_box, bb_hit;
    logic                 inx, iny, edge_x, edge_y;

    assign ax = DW'(in_a_x_reg);
    assign ay = DW'(in_a_y_reg);
    assign aw = DW'(in_a_w_reg);
    assign ah = DW'(in_a_h_reg);
    assign bx = DW'(in_b_x_reg);
    assign by = DW'(in_b_y_reg);
    assign bw = DW'(in_b_w_reg);
    assign bh = DW'(in_b_h_reg);

    assign both_circ = in_a_circle_reg && in_b_circle_reg;
    assign both_box  = !in_a_circle_reg && !in_b_circle_reg;

    // Closed-interval overlap on both axes
    assign bb_hit = !((ax > bx + bw) || (ax + aw < bx) ||
                      (ay > by + bh) || (ay + ah < by));

    // Circle is a when a is a circle, else b; the other shape is the box
    assign cx  = in_a_circle_reg ? ax : bx;
    assign cy  = in_a_circle_reg ? ay : by;
    assign cw  = in_a_circle_reg ? aw : bw;
    assign lx  = in_a_circle_reg ? bx : ax;
    assign ty  = in_a_circle_reg ? by : ay;
    assign ow  = in_a_circle_reg ? bw : aw;
    assign oh  = in_a_circle_reg ? bh : ah;
    assign rx  = lx + ow;
    assign byt = ty + oh;

    assign inx    = (cx >= lx) && (cx <= rx);
    assign iny    = (cy >= ty) && (cy <= byt);
    assign edge_y = ((cy < ty) && (ty - cy <= cw)) || ((cy > byt) && (cy - byt <= cw));
    assign edge_x = ((cx < lx) && (lx - cx <= cw)) || ((cx > rx) && (cx - rx <= cw));

    // For circle vs circle, dxl / dyt are the centre-to-centre deltas
    assign dxl = lx - cx;
    assign dxr = rx - cx;
    assign dyt = ty - cy;
    assign dyb = byt - cy;

    assign pxl = dxl * dxl;
    assign pxr = dxr * dxr;
    assign pyt = dyt * dyt;
    assign pyb = dyb * dyb;

    assign lim    = both_circ ? (LW'(in_a_w_reg) + LW'(in_b_w_reg) + LW'(1))
                              : LW'(cw[SZW-1:0]);
    assign lim_sq = (2*LW)'(lim) * (2*LW)'(lim);

    mode_t            sq_mode_next;
    logic             sq_flag_next;

    always_comb
    begin
        sq_mode_next = MODE_FLAG;
        sq_flag_next = 1'b0;
        if (in_a_unused_reg || in_b_unused_reg)
        begin
            sq_mode_next = MODE_FLAG;
            sq_flag_next = 1'b0;
        end
        else if (both_box)
        begin
            sq_flag_next = bb_hit;
        end
        else if (both_circ)
        begin
            sq_mode_next = MODE_CC;
        end
        else if (inx && iny)
        begin
            sq_flag_next = 1'b1;
        end
        else if (inx)
        begin
            sq_flag_next = edge_y;
        end
        else if (iny)
        begin
            sq_flag_next = edge_x;
        end
        else
        begin
            sq_mode_next = MODE_CORNER;
        end
    end

    logic             sq_vld_reg;
    mode_t            sq_mode_reg;
    logic             sq_flag_reg;
    logic [SQW-1:0]   sq_xl_reg, sq_xr_reg, sq_yt_reg, sq_yb_reg;
    logic [2*LW-1:0]  sq_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            sq_mode_reg <= sq_mode_next;
            sq_flag_reg <= sq_flag_next;
            sq_xl_reg   <= pxl[SQW-1:0];
            sq_xr_reg   <= pxr[SQW-1:0];
            sq_yt_reg   <= pyt[SQW-1:0];
            sq_yb_reg   <= pyb[SQW-1:0];
            sq_lim_reg  <= lim_sq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum of squares against threshold
    // ------------------------------------------------------------------
    logic [SW-1:0] d_tl, d_tr, d_bl, d_br, thr;
    logic          hit_next;

    assign d_tl = SW'(sq_xl_reg) + SW'(sq_yt_reg);
    assign d_tr = SW'(sq_xr_reg) + SW'(sq_yt_reg);
    assign d_bl = SW'(sq_xl_reg) + SW'(sq_yb_reg);
    assign d_br = SW'(sq_xr_reg) + SW'(sq_yb_reg);
    assign thr  = SW'(sq_lim_reg);

    always_comb
    begin
        case (sq_mode_reg)
            MODE_FLAG:   hit_next = sq_flag_reg;
            MODE_CC:     hit_next = (d_tl < thr);
            MODE_CORNER: hit_next = (d_tl <= thr) || (d_tr <= thr) ||
                                    (d_bl <= thr) || (d_br <= thr);
            default:     hit_next = 1'b0;
        endcase
    end

    logic done_reg;
    logic hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_vld_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every accepted pair produces a result beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result beat missing after accepted pair");

    // No result beat without an earlier accepted pair
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##3 !done)
        else $error("result beat without accepted pair");

    // An unused shape forces no hit
    a_unused_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (a_unused || b_unused)) |-> ##3 !hit)
        else $error("hit reported for unused shape");

    // Two identical active shapes always overlap
    a_self_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !a_unused && !b_unused && (a_circle == b_circle) &&
         (a_x == b_x) && (a_y == b_y) && (a_w == b_w) && (a_h == b_h))
        |-> ##3 hit)
        else $error("identical shapes reported as no hit");

endmodule
